/* rtl/nfsa_pkg.sv */
// shared types, codes and field widths of the next-fit slot allocator
`default_nettype none

package nfsa_pkg;

    // bitmap is held as words of this many slots
    localparam int WORD_W = 32;
    localparam int OFS_W  = 5;

    // field widths
    localparam int OP_W   = 2;
    localparam int SID_W  = 10;
    localparam int SLOT_W = 9;
    localparam int HW_W   = 10;

    // stream widths, whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PICK,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic search;
        logic pick;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* rtl/nfsa_ctrl.sv */
// sequencing state machine of the next-fit slot allocator
`default_nettype none

module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_status         i_status,
    output logic                 o_s_tready,
    output t_cmd                 o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_op == OP_ALLOC) ? S_SEARCH : S_COMMIT;
                end
            end
            S_SEARCH: n_state = S_PICK;
            S_PICK:   n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_SEARCH: o_cmd.search = 1'b1;
            S_PICK:   o_cmd.pick   = 1'b1;
            S_COMMIT: o_cmd.commit = i_status.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/nfsa_datapath.sv */
// bitmap words, free summary, search pointer, high-water mark and result register
`default_nettype none

module nfsa_datapath
    import nfsa_pkg::*;
#(
    parameter int POOL_SIZE = 512
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic [OP_W-1:0]        i_op,
    input  wire logic [SID_W-1:0]       i_sid,
    input  wire logic                   i_m_tready,
    output t_status                     o_status,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [0:0]                  o_m_tuser
);

    localparam int NW     = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (NW > 1) ? $clog2(NW) : 1;
    localparam int NWP    = 1 << WIDX_W;
    localparam int IDX_W  = WIDX_W + OFS_W;
    localparam int HWM_W  = IDX_W + 1;
    localparam logic [SID_W:0]   POOL_LIM = (SID_W+1)'(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // slots past the end of the pool read as used
    function automatic logic [WORD_W-1:0] pad_word(input int w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (w * WORD_W + b >= POOL_SIZE) m[b] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [NWP-1:0] avail_init();
        logic [NWP-1:0] a;
        a = '0;
        for (int w = 0; w < NWP; w++) begin
            a[w] = (w * WORD_W < POOL_SIZE);
        end
        return a;
    endfunction

    function automatic logic [WIDX_W-1:0] first_word(input logic [NWP-1:0] v);
        logic [WIDX_W-1:0] k;
        k = '0;
        for (int i = NWP - 1; i >= 0; i--) begin
            if (v[i]) k = WIDX_W'(i);
        end
        return k;
    endfunction

    function automatic logic [OFS_W-1:0] first_bit(input logic [WORD_W-1:0] v);
        logic [OFS_W-1:0] k;
        k = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) k = OFS_W'(i);
        end
        return k;
    endfunction

    logic [WORD_W-1:0] r_map [NWP];
    logic [NWP-1:0]    r_avail;
    logic [IDX_W-1:0]  r_ptr;
    logic [HWM_W-1:0]  r_hwm;
    logic [OP_W-1:0]   r_op;
    logic [SID_W-1:0]  r_sid;
    logic [WIDX_W-1:0] r_widx;
    logic              r_lo_mask;
    logic              r_found;
    logic [IDX_W-1:0]  r_cand;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_ok;
    logic [HW_W-1:0]   r_out_hw;

    logic [WORD_W-1:0] pad_tab [NWP];
    logic [WIDX_W-1:0] sw;
    logic [OFS_W-1:0]  so;
    logic [WORD_W-1:0] ge_mask;
    logic [IDX_W-1:0]  sid_i;
    logic [WIDX_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] rd_used;
    logic [WORD_W-1:0] free_hi;
    logic              hit_hi;
    logic [2*NWP-1:0]  avail_dbl;
    logic [2*NWP-1:0]  avail_rot;
    logic [WIDX_W:0]   rot_amt;
    logic [WIDX_W-1:0] widx_rot;
    logic [WORD_W-1:0] pick_free;
    logic              sid_ok;
    logic [HWM_W-1:0]  cand_p1;
    logic [WORD_W-1:0] cand_hot;
    logic [WORD_W-1:0] sid_hot;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_idx;
    logic [WORD_W-1:0] wr_word;
    logic              avail_val;
    logic [IDX_W-1:0]  n_ptr;
    logic [HWM_W-1:0]  n_hwm;
    logic [SLOT_W-1:0] n_out_slot;
    logic              n_out_ok;

    always_comb begin
        for (int w = 0; w < NWP; w++) begin
            pad_tab[w] = pad_word(w);
        end
    end

    assign sw      = r_ptr[IDX_W-1:OFS_W];
    assign so      = r_ptr[OFS_W-1:0];
    assign ge_mask = {WORD_W{1'b1}} << so;
    assign sid_i   = IDX_W'(r_sid);
    assign sid_ok  = ({1'b0, r_sid} < POOL_LIM);

    // single read port on the bitmap words
    always_comb begin
        if (i_cmd.search) begin
            rd_addr = sw;
        end else if (r_op != OP_ALLOC) begin
            rd_addr = sid_i[IDX_W-1:OFS_W];
        end else begin
            rd_addr = r_widx;
        end
    end

    assign rd_word = r_map[rd_addr];
    assign rd_used = rd_word | pad_tab[rd_addr];

    // search: upper part of the start word, else next word with a free slot
    assign free_hi   = ~rd_used & ge_mask;
    assign hit_hi    = |free_hi;
    assign avail_dbl = {r_avail, r_avail};
    assign rot_amt   = (WIDX_W+1)'(sw) + (WIDX_W+1)'(1);
    assign avail_rot = avail_dbl >> rot_amt;
    assign widx_rot  = sw + WIDX_W'(1) + first_word(avail_rot[NWP-1:0]);

    // pick: lowest free slot in the chosen word, at or above the start offset when the upper part hit
    assign pick_free = ~rd_used & (r_lo_mask ? ge_mask : {WORD_W{1'b1}});

    assign cand_p1  = HWM_W'(r_cand) + HWM_W'(1);
    assign cand_hot = WORD_W'(1) << r_cand[OFS_W-1:0];
    assign sid_hot  = WORD_W'(1) << sid_i[OFS_W-1:0];

    // commit
    always_comb begin
        wr_en      = 1'b0;
        wr_idx     = r_widx;
        wr_word    = rd_word;
        avail_val  = 1'b0;
        n_ptr      = r_ptr;
        n_hwm      = r_hwm;
        n_out_slot = '0;
        n_out_ok   = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (r_found) begin
                    wr_en      = 1'b1;
                    wr_word    = rd_word | cand_hot;
                    avail_val  = ~&(rd_used | cand_hot);
                    n_ptr      = (r_cand == LAST_IDX) ? '0 : r_cand + IDX_W'(1);
                    n_hwm      = (cand_p1 > r_hwm) ? cand_p1 : r_hwm;
                    n_out_slot = SLOT_W'(r_cand);
                    n_out_ok   = 1'b1;
                end
            end
            OP_FREE: begin
                n_out_ok = 1'b1;
                if (sid_ok) begin
                    wr_en     = 1'b1;
                    wr_idx    = sid_i[IDX_W-1:OFS_W];
                    wr_word   = rd_word & ~sid_hot;
                    avail_val = 1'b1;
                end
            end
            OP_QUERY: begin
                n_out_ok = sid_ok & rd_word[sid_i[OFS_W-1:0]];
            end
            default: begin
                n_out_ok = 1'b0;
            end
        endcase
    end

    // control and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NWP; w++) begin
                r_map[w] <= '0;
            end
            r_avail     <= avail_init();
            r_ptr       <= '0;
            r_hwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (wr_en) begin
                    r_map[wr_idx]   <= wr_word;
                    r_avail[wr_idx] <= avail_val;
                end
                r_ptr       <= n_ptr;
                r_hwm       <= n_hwm;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_sid <= i_sid;
        end
        if (i_cmd.search) begin
            r_widx    <= hit_hi ? sw : widx_rot;
            r_lo_mask <= hit_hi;
            r_found   <= hit_hi | (|r_avail);
        end
        if (i_cmd.pick) begin
            r_cand <= {r_widx, first_bit(pick_free)};
        end
        if (i_cmd.commit) begin
            r_out_slot <= n_out_slot;
            r_out_ok   <= n_out_ok;
            r_out_hw   <= HW_W'(n_hwm);
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = OUT_TDATA_W'({r_out_hw, r_out_slot});
    assign o_m_tuser         = r_out_ok;

    // a result is only loaded when the output register can take it
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken result");

    // a successful search always leaves a free slot for the pick step
    a_pick_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pick && r_op == OP_ALLOC && r_found) |-> (|pick_free))
        else $error("search reported a free slot that the pick step cannot find");

    // next-fit pointer stays inside the pool
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HWM_W'(r_ptr) < HWM_W'(POOL_SIZE)))
        else $error("search pointer outside the pool");

    // high-water mark never falls
    a_hwm_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_hwm >= $past(r_hwm)))
        else $error("high-water mark fell");

endmodule

`default_nettype wire

/* rtl/next_fit_slot_allocator_unit.sv */
// top level of the next-fit slot allocator: controller plus datapath
//
// usage
//   requests arrive on the slave stream: tuser carries the operation
//   (allocate, free, query), tdata carries the slot id. one result
//   leaves on the master stream per request: tdata holds the granted slot
//   and the high-water mark after the operation, tuser holds the ok flag.
//   sequence
//   an allocate runs through these steps before its result is shown
//   and the next request is taken: pick the word (upper part of the
//   start word, else a rotated search over the per-word free summary),
//   find the bit inside that word, write back the word and register the
//   result. free, query and unknown codes go straight to the write back.
//   the steps are set by the single read port on the bitmap words and
//   the word-then-bit search.
//   stalls
//   a finished result sits in the output register; the next request is
//   still taken, and its write back waits until the old result has gone.
//   reset
//   synchronous, active low; every slot is free, pointer and high-water
//   mark are zero, no result is pending. no clearing pass is needed.
`default_nettype none

module next_fit_slot_allocator_unit
    import nfsa_pkg::*;
#(
    parameter int POOL_SIZE = 512
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] slot_id, rest zero
    input  wire logic [OP_W-1:0]        i_s_tuser,   // [1:0] operation
    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [8:0] granted_slot, [18:9] high_water
    output logic [0:0]                  o_m_tuser    // [0] ok
);

    t_cmd    cmd;
    t_status status;

    // sequencer: idle, search, pick, write back
    nfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // bitmap, pointer, high-water mark and result register
    nfsa_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_op       (i_s_tuser),
        .i_sid      (i_s_tdata[SID_W-1:0]),
        .i_m_tready (i_m_tready),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* tb/sv/nfsa_result_checker.sv */
// result checker for the next-fit slot allocator: tracks the pool and compares every result
module nfsa_result_checker
    import nfsa_pkg::*;
#(
    parameter int POOL_SIZE = 512
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] slot_id
    input  wire logic [OP_W-1:0]        i_s_tuser,   // [1:0] operation
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,   // [8:0] granted_slot, [18:9] high_water
    input  wire logic [0:0]             i_m_tuser,   // [0] ok
    output int                          o_pending,
    output int                          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              ok;
        logic [HW_W-1:0]   hw;
    } t_outcome;

    bit          slot_used [POOL_SIZE];
    int unsigned next_fit_ptr;
    int unsigned hw_mark;
    t_outcome    outcome_q [$];
    int          n_reqs = 0;
    int          n_rsps = 0;
    int          n_fail = 0;

    assign o_pending    = n_reqs - n_rsps;
    assign o_fail_count = n_fail;

    // applies one request to the tracked pool and returns the result it should give
    function automatic t_outcome apply_request(input logic [OP_W-1:0] op,
                                               input int unsigned sid);
        t_outcome    res;
        int unsigned cand;
        bit          found;
        res   = '0;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                // next fit: first free slot at or after the pointer, wrapping round
                for (int n = 0; n < POOL_SIZE && !found; n++) begin
                    cand = (next_fit_ptr + n) % POOL_SIZE;
                    if (!slot_used[cand]) begin
                        found           = 1'b1;
                        slot_used[cand] = 1'b1;
                        if (cand + 1 > hw_mark)
                            hw_mark = cand + 1;
                        next_fit_ptr = (cand + 1) % POOL_SIZE;
                        res.slot     = cand[SLOT_W-1:0];
                        res.ok       = 1'b1;
                    end
                end
            end
            OP_FREE: begin
                if (sid < POOL_SIZE)
                    slot_used[sid] = 1'b0;
                res.ok = 1'b1;
            end
            OP_QUERY: begin
                res.ok = (sid < POOL_SIZE) ? slot_used[sid] : 1'b0;
            end
            default: ;
        endcase
        res.hw = hw_mark[HW_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch on result %0d, expected %0d, actual %0d",
                     $time, name, n_rsps, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            next_fit_ptr = 0;
            hw_mark      = 0;
            outcome_q.delete();
            n_reqs <= 0;
            n_rsps <= 0;
        end else begin
            // results first: none can stem from a request taken at this same edge
            if (i_m_tvalid && i_m_tready) begin
                got.slot = i_m_tdata[SLOT_W-1:0];
                got.hw   = i_m_tdata[SLOT_W +: HW_W];
                got.ok   = i_m_tuser[0];
                n_rsps <= n_rsps + 1;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding, slot %0d ok %0d hw %0d",
                             $time, got.slot, got.ok, got.hw);
                    n_fail++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("granted_slot", 32'(want.slot), 32'(got.slot));
                    check_field("ok", 32'(want.ok), 32'(got.ok));
                    check_field("high_water", 32'(want.hw), 32'(got.hw));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                outcome_q.push_back(apply_request(i_s_tuser, 32'(i_s_tdata[SID_W-1:0])));
                n_reqs <= n_reqs + 1;
            end
        end
    end

endmodule

/* tb/sv/tb_next_fit_slot_allocator_unit.sv */
// testbench top for the next-fit slot allocator: clock, reset, request stimulus and verdict
module tb_next_fit_slot_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import nfsa_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int POOL       = 512;
    localparam int SID_MAX    = (1 << SID_W) - 1;
    // the fourth operation code, which the block must answer without side effects
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [IN_TDATA_W-1:0]  req_data  = '0;
    logic [OP_W-1:0]        req_op    = OP_ALLOC;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] rsp_data;
    logic [0:0]             rsp_ok;
    int                     pending;
    int                     fail_count;

    // idle percentages for each side, changed per phase
    int tx_idle_pct = 34;
    int rx_idle_pct = 71;
    int n_by_op [4] = '{default: 0};

    always #(CLK_PERIOD / 2) clk = ~clk;

    next_fit_slot_allocator_unit #(
        .POOL_SIZE (POOL)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (req_valid),
        .o_s_tready (req_ready),
        .i_s_tdata  (req_data),
        .i_s_tuser  (req_op),
        .o_m_tvalid (rsp_valid),
        .i_m_tready (rsp_ready),
        .o_m_tdata  (rsp_data),
        .o_m_tuser  (rsp_ok)
    );

    nfsa_result_checker #(
        .POOL_SIZE (POOL)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (req_valid),
        .i_s_tready   (req_ready),
        .i_s_tdata    (req_data),
        .i_s_tuser    (req_op),
        .i_m_tvalid   (rsp_valid),
        .i_m_tready   (rsp_ready),
        .i_m_tdata    (rsp_data),
        .i_m_tuser    (rsp_ok),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk) begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // one request transfer; valid stays high into the next call unless that call idles
    task automatic issue(input logic [OP_W-1:0] op, input logic [SID_W-1:0] sid);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_data  <= {{(IN_TDATA_W - SID_W){1'b0}}, sid};
        n_by_op[op]++;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // hold off the request side until every outstanding result has been taken
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending > 0);
    endtask

    // mixed traffic; ids mostly inside the span, the rest beyond the pool
    task automatic issue_random(input int count, input int alloc_pct, input int id_span);
        logic [OP_W-1:0]  op;
        logic [SID_W-1:0] sid;
        int               r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                op = OP_ALLOC;
            end else begin
                r  = $urandom_range(0, 99);
                op = (r < 50) ? OP_FREE : (r < 92) ? OP_QUERY : OP_UNKNOWN;
            end
            if ($urandom_range(0, 99) < 85)
                sid = SID_W'($urandom_range(0, id_span - 1));
            else
                sid = SID_W'($urandom_range(POOL, SID_MAX));
            issue(op, sid);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first grants, query hit and miss, free of a free slot,
        // next fit skipping a freed slot, out-of-range ids, the unknown code
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, SID_W'(SID_MAX));
        issue(OP_QUERY, 10'd0);
        issue(OP_QUERY, 10'd2);
        issue(OP_FREE, 10'd0);
        issue(OP_QUERY, 10'd0);
        issue(OP_FREE, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_FREE, SID_W'(SID_MAX));
        issue(OP_FREE, SID_W'(POOL));
        issue(OP_QUERY, SID_W'(SID_MAX));
        issue(OP_QUERY, SID_W'(POOL));
        issue(OP_QUERY, SID_W'(POOL - 1));
        issue(OP_UNKNOWN, SID_W'(SID_MAX));
        issue(OP_UNKNOWN, 10'd0);
        issue(OP_FREE, 10'd1);
        issue(OP_ALLOC, 10'h155);
        issue(OP_QUERY, 10'd3);
        issue(OP_FREE, 10'd2);
        issue(OP_FREE, 10'd3);
        issue(OP_ALLOC, 10'h2AA);
        wait_drained();

        // phase one: light occupancy, ids kept near the allocated region
        issue_random(220, 40, 128);
        wait_drained();

        // phase two: pacing swapped; fill the whole pool, wrap the pointer,
        // run into exhaustion, then churn on a full pool
        tx_idle_pct = 71;
        rx_idle_pct = 34;
        repeat (520)
            issue(OP_ALLOC, SID_W'($urandom_range(0, SID_MAX)));
        issue_random(80, 50, POOL);
        wait_drained();

        // phase three: back-to-back transfers on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        issue_random(110, 40, POOL);
        wait_drained();

        // allow the block's own latency to expose any stray result
        repeat (12) @(posedge clk);

        $display("covered %0d requests: %0d allocate, %0d free, %0d query, %0d unknown code",
                 n_by_op[0] + n_by_op[1] + n_by_op[2] + n_by_op[3],
                 n_by_op[OP_ALLOC], n_by_op[OP_FREE], n_by_op[OP_QUERY], n_by_op[OP_UNKNOWN]);
        $display("pool filled to exhaustion and wrapped, under three stall patterns");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/nfsa_pkg.sv
rtl/nfsa_ctrl.sv
rtl/nfsa_datapath.sv
rtl/next_fit_slot_allocator_unit.sv
tb/sv/nfsa_result_checker.sv
tb/sv/tb_next_fit_slot_allocator_unit.sv
